[rtl/rtcc_pkg.sv]
package rtcc_pkg;

    // Channel geometry: three byte-wide channels per pixel.
    localparam int CHAN_W      = 8;
    localparam int NUM_LANES   = 3;
    localparam int TDATA_W     = NUM_LANES * CHAN_W;

    // One quotient bit is resolved per divider stage.
    localparam int DIV_STAGES  = CHAN_W;
    // Peak/difference stage followed by the divider stages.
    localparam int PIPE_STAGES = DIV_STAGES + 1;
    // Partial remainder holds the scaled difference, up to 255 * 255.
    localparam int REM_W       = 2 * CHAN_W;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [REM_W-1:0]  rem_t;

    // Per-stage load enables, shared by the peak stage and all lanes.
    typedef struct packed {
        logic                  peak_en;
        logic [DIV_STAGES-1:0] div_en;
    } rtcc_ctrl_t;

endpackage

[rtl/rtcc_peak.sv]
module rtcc_peak
    import rtcc_pkg::*;
(
    input  logic                        aclk,
    input  rtcc_ctrl_t                  ctrl,
    input  chan_t      [NUM_LANES-1:0]  chan_in,
    output chan_t                       peak_out,
    output chan_t      [NUM_LANES-1:0]  diff_out,
    output logic                        zero_out
);

    chan_t                 peak_next;
    chan_t                 peak_reg;
    chan_t [NUM_LANES-1:0] diff_next;
    chan_t [NUM_LANES-1:0] diff_reg;
    logic                  zero_next;
    logic                  zero_reg;

    // Largest channel, then each channel's distance below it.
    always_comb begin
        peak_next = chan_in[0];
        for (int i = 1; i < NUM_LANES; i++) begin
            if (chan_in[i] > peak_next) begin
                peak_next = chan_in[i];
            end
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            diff_next[i] = peak_next - chan_in[i];
        end
        zero_next = (peak_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.peak_en) begin
            peak_reg <= peak_next;
            diff_reg <= diff_next;
            zero_reg <= zero_next;
        end
    end

    assign peak_out = peak_reg;
    assign diff_out = diff_reg;
    assign zero_out = zero_reg;

endmodule

[rtl/rtcc_lane.sv]
module rtcc_lane
    import rtcc_pkg::*;
(
    input  logic       aclk,
    input  rtcc_ctrl_t ctrl,
    input  chan_t      peak_in,
    input  chan_t      diff_in,
    input  logic       zero_in,
    output chan_t      quo_out
);

    // Restoring division of diff * 255 by the peak, one quotient bit per stage.
    // The quotient always fits in CHAN_W bits because diff never exceeds the peak.
    rem_t  rem_reg  [DIV_STAGES];
    chan_t quo_reg  [DIV_STAGES];
    chan_t div_reg  [DIV_STAGES];
    logic  zero_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            localparam int BIT = DIV_STAGES - 1 - s;

            rem_t  rem_cur;
            chan_t quo_cur;
            chan_t div_cur;
            logic  zero_cur;
            rem_t  trial;
            logic  take;
            rem_t  rem_next;
            chan_t quo_next;

            if (s == 0) begin : g_first
                // diff * 255 as (diff << 8) - diff.
                assign rem_cur  = {diff_in, CHAN_W'(0)} - REM_W'(diff_in);
                assign quo_cur  = '0;
                assign div_cur  = peak_in;
                assign zero_cur = zero_in;
            end else begin : g_next
                assign rem_cur  = rem_reg[s-1];
                assign quo_cur  = quo_reg[s-1];
                assign div_cur  = div_reg[s-1];
                assign zero_cur = zero_reg[s-1];
            end

            always_comb begin
                trial         = REM_W'(div_cur) << BIT;
                take          = (rem_cur >= trial);
                rem_next      = take ? (rem_cur - trial) : rem_cur;
                quo_next      = quo_cur;
                quo_next[BIT] = take;
            end

            always_ff @(posedge aclk) begin
                if (ctrl.div_en[s]) begin
                    rem_reg[s]  <= rem_next;
                    quo_reg[s]  <= quo_next;
                    div_reg[s]  <= div_cur;
                    zero_reg[s] <= zero_cur;
                end
            end
        end
    endgenerate

    // A black pixel has no divisor; its components are defined as zero.
    assign quo_out = zero_reg[DIV_STAGES-1] ? '0 : quo_reg[DIV_STAGES-1];

endmodule

[rtl/rgb_to_cmy_pixel_convert.sv]
// A pixel transferred on s_ moves through one peak stage, eight divider stages
// (one quotient bit each) and the output register, and then shows on m_tvalid.
// Throughput: one pixel per cycle, sustained, when m_tready stays high; all
// stages then advance together.
// Reset: aresetn is synchronous and active low; it empties every stage and the
// output register, and the block accepts pixels in the first cycle after it.
module rgb_to_cmy_pixel_convert
    import rtcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_tvalid,
    output logic               s_tready,
    // Fields from bit 0 up: chan_first [7:0], chan_second [15:8], chan_third [23:16].
    input  logic [TDATA_W-1:0] s_tdata,

    output logic               m_tvalid,
    input  logic               m_tready,
    // Fields from bit 0 up: cyan_out [7:0], magenta_out [15:8], yellow_out [23:16].
    output logic [TDATA_W-1:0] m_tdata
);

    // Each pipeline stage carries a valid bit. A stage may load whenever it is
    // empty or the stage after it loads in the same cycle, so bubbles collapse
    // and the input keeps taking pixels, until every stage is full, while a
    // finished result waits at the output register.
    logic [PIPE_STAGES-1:0] v_reg;
    logic [PIPE_STAGES-1:0] v_next;
    logic [PIPE_STAGES:0]   rdy;
    logic                   out_ready;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [TDATA_W-1:0]     m_tdata_reg;
    logic [TDATA_W-1:0]     m_tdata_next;

    rtcc_ctrl_t             ctrl;

    chan_t [NUM_LANES-1:0]  chan;
    chan_t                  peak;
    chan_t [NUM_LANES-1:0]  diff;
    logic                   peak_zero;
    chan_t [NUM_LANES-1:0]  quo;

    // The output register can take a new result when it is empty or its
    // current result is being transferred out this cycle.
    assign out_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        rdy[PIPE_STAGES] = out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready     = rdy[0];
    assign ctrl.peak_en = rdy[0];
    // Divider stage s sits behind valid bit s+1.
    assign ctrl.div_en  = rdy[PIPE_STAGES-1:1];

    always_comb begin
        v_next[0] = rdy[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
        m_tvalid_next = out_ready ? v_reg[PIPE_STAGES-1] : m_tvalid_reg;
    end

    // Unpack the three channels of the incoming pixel.
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            chan[i] = s_tdata[i*CHAN_W +: CHAN_W];
        end
    end

    // Front stage: channel maximum and per-channel differences.
    rtcc_peak u_peak (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .chan_in  (chan),
        .peak_out (peak),
        .diff_out (diff),
        .zero_out (peak_zero)
    );

    // One divider lane per channel, all sharing the same stage enables.
    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            rtcc_lane u_lane (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .peak_in (peak),
                .diff_in (diff[g]),
                .zero_in (peak_zero),
                .quo_out (quo[g])
            );
        end
    endgenerate

    // Merge the three lane quotients into one result word.
    always_comb begin
        m_tdata_next = m_tdata_reg;
        if (out_ready) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                m_tdata_next[i*CHAN_W +: CHAN_W] = quo[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            v_reg        <= v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // A transfer on the input side always lands in the front stage.
    a_accept_fills_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted pixel did not enter the front stage");

    // With every stage full and the output stalled, no pixel may be taken.
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&v_reg) && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is full and stalled");

    // A stalled last stage keeps its pixel.
    a_last_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[PIPE_STAGES-1] && !out_ready) |=> v_reg[PIPE_STAGES-1])
        else $error("last divider stage dropped a pixel under stall");

    // A result only appears when the last divider stage held a pixel.
    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v_reg[PIPE_STAGES-1]))
        else $error("result appeared without a pixel in the last stage");
`endif

endmodule

[tb/sv/rgb_to_cmy_pixel_convert_tb.sv]
`timescale 1ns / 1ps

module rgb_to_cmy_pixel_convert_tb;
    import rtcc_pkg::*;

    // Full-scale value of a chromatic component.
    localparam int FULL_SCALE  = 255;
    // A pixel passes through every pipeline stage and the output register to its result.
    // Pauses add a small margin on top of that.
    localparam int DRAIN_CYCLES = PIPE_STAGES + 4;
    // The slowest correct run sends 452 pixels, each with the longest sender idle
    // time, the longest receiver stall and its pass through the pipeline. This
    // limit lies far above the length of such a run.
    localparam int CYCLE_LIMIT = 200000;

    // One expected result. The fields are in the same order as the fields
    // of m_tdata, so the struct can be compared with it field by field.
    typedef struct packed {
        chan_t yellow;
        chan_t magenta;
        chan_t cyan;
    } cmy_pixel_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    // Fields from bit 0 up: chan_first [7:0], chan_second [15:8], chan_third [23:16].
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    // Fields from bit 0 up: cyan_out [7:0], magenta_out [15:8], yellow_out [23:16].
    logic [TDATA_W-1:0] m_tdata;

    // This queue holds the results that are expected but have not yet arrived,
    // oldest first.
    cmy_pixel_t cmy_expected_q[$];
    int         error_count = 0;
    int         cycle_count = 0;
    // When this is low, neither side idles. Both then run at the full rate.
    bit         gaps_on = 1'b1;
    // This is the number of cycles the receiver still holds m_tready low
    // before it takes the next result.
    int         rx_hold = 0;

    rgb_to_cmy_pixel_convert DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The cycle counter stops a hung run. It prints the fail message, because
    // a timeout is a failure in its own right.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL rgb_to_cmy_pixel_convert");
            $finish;
        end
    end

    // This is one chromatic component: (peak - chan) * 255 / peak, truncated.
    // The product needs at most 16 bits, because 255 * 255 fits in rem_t.
    function automatic chan_t chroma_scale(input chan_t peak, input chan_t chan);
        rem_t scaled;
        scaled = rem_t'(peak - chan) * rem_t'(FULL_SCALE);
        return chan_t'(scaled / rem_t'(peak));
    endfunction

    // This predicts the CMY part of the CMYK conversion of one pixel. A black
    // pixel has no peak to divide by, so it gives all zeros.
    function automatic cmy_pixel_t cmy_from_rgb(input chan_t first, input chan_t second,
                                                input chan_t third);
        chan_t      peak;
        cmy_pixel_t res;
        peak = first;
        if (second > peak) peak = second;
        if (third > peak) peak = third;
        if (peak == '0) begin
            res = '0;
        end else begin
            res.cyan    = chroma_scale(peak, first);
            res.magenta = chroma_scale(peak, second);
            res.yellow  = chroma_scale(peak, third);
        end
        return res;
    endfunction

    // Each mismatch gives one line of output and adds one to the error count.
    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, expected, got);
        error_count++;
    endtask

    // Each side may idle before each transfer. A quarter of the draws give no idling, and the
    // rest draw a random idle time that may also be none, so some transfers come back to back.
    function automatic int draw_wait();
        if (!gaps_on || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 6);
    endfunction

    // This task sends one pixel. It drives the input at the falling edge. A
    // pixel that follows without a gap keeps s_tvalid high, so the signal is
    // never lowered and raised again in the same time step. The expected
    // result is stored when the transfer happens.
    task automatic send_pixel(input chan_t first, input chan_t second, input chan_t third);
        int gap;
        gap = draw_wait();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {third, second, first};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cmy_expected_q.push_back(cmy_from_rgb(first, second, third));
    endtask

    // This task lowers s_tvalid. It then waits until every expected result has
    // arrived and for DRAIN_CYCLES after that. The sender thus pauses
    // with the block fully drained.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (cmy_expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver: m_tready goes low at the falling edge for the number of cycles
    // drawn after the last result. It then stays high until the next result
    // is taken.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Checker: each result transfer is compared with the oldest expected
    // result, one field at a time. A result that arrives when nothing is
    // expected is a failure as well.
    always @(posedge aclk) begin
        cmy_pixel_t want;
        cmy_pixel_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = cmy_pixel_t'(m_tdata);
            if (cmy_expected_q.size() == 0) begin
                report_mismatch("unexpected result, m_tdata", 0, int'(m_tdata));
            end else begin
                want = cmy_expected_q.pop_front();
                if (got.cyan != want.cyan)
                    report_mismatch("cyan_out", want.cyan, got.cyan);
                if (got.magenta != want.magenta)
                    report_mismatch("magenta_out", want.magenta, got.magenta);
                if (got.yellow != want.yellow)
                    report_mismatch("yellow_out", want.yellow, got.yellow);
            end
            rx_hold = draw_wait();
        end
    end

    // This test sends corner pixels: black, white, pure and faint primaries,
    // grays, ties for the maximum, and pixels whose division has a large
    // remainder. The values 0 and 255 set every bit of every channel both ways.
    task automatic test_corner_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd254, 8'd1);
        send_pixel(8'd254, 8'd255, 8'd253);
        send_pixel(8'd2,   8'd1,   8'd0);
        send_pixel(8'd3,   8'd2,   8'd1);
        send_pixel(8'd128, 8'd64,  8'd32);
        send_pixel(8'd170, 8'd85,  8'd1);
        send_pixel(8'd127, 8'd128, 8'd129);
        send_pixel(8'd85,  8'd170, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd0);
        drain_pipeline();
    endtask

    // This test sends random pixels with random idle cycles on both sides.
    task automatic test_random_pixels(input int count);
        repeat (count)
            send_pixel(chan_t'($urandom_range(0, 255)), chan_t'($urandom_range(0, 255)),
                       chan_t'($urandom_range(0, 255)));
        drain_pipeline();
    endtask

    // This test sends pixels back to back with the receiver always ready. The
    // pipeline then runs full at one pixel per cycle.
    task automatic test_full_rate(input int count);
        gaps_on = 1'b0;
        repeat (count)
            send_pixel(chan_t'($urandom_range(0, 255)), chan_t'($urandom_range(0, 255)),
                       chan_t'($urandom_range(0, 255)));
        drain_pipeline();
        gaps_on = 1'b1;
    endtask

    // This test sends dark and near-gray pixels. A small peak, or channels close
    // to it, puts the divider near its edges: a small divisor, a quotient near
    // 0 or near 255, and pixels that are black or almost black.
    task automatic test_dark_pixels(input int count);
        chan_t base;
        repeat (count) begin
            if ($urandom_range(0, 1) == 0) begin
                send_pixel(chan_t'($urandom_range(0, 7)), chan_t'($urandom_range(0, 7)),
                           chan_t'($urandom_range(0, 7)));
            end else begin
                base = chan_t'($urandom_range(4, 255));
                send_pixel(base - chan_t'($urandom_range(0, 4)),
                           base - chan_t'($urandom_range(0, 4)),
                           base - chan_t'($urandom_range(0, 4)));
            end
        end
        drain_pipeline();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        test_corner_pixels();
        test_random_pixels(200);
        test_full_rate(130);
        test_dark_pixels(100);

        if (error_count == 0) begin
            $display("PASS rgb_to_cmy_pixel_convert");
        end else begin
            $display("FAIL rgb_to_cmy_pixel_convert");
        end
        $finish;
    end

endmodule
